// ===== hw/rtl/scs1kd_pkg.sv =====
package scs1kd_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int QIDX_W      = $clog2(QUEUE_SLOTS);

  localparam logic       OP_SCAN    = 1'b0;
  localparam logic       OP_POP     = 1'b1;

  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [7:0] BYTE_PAUSE = 8'hE1;

  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CAPS    = 7'h3A;

  localparam logic [7:0] KC_NONE    = 8'd0;
  localparam logic [7:0] KC_RCTRL   = 8'd138;
  localparam logic [7:0] KC_RALT    = 8'd139;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_PUSH   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef struct packed {
    logic [3:0] mods;
    logic [6:0] ascii;
    logic [7:0] key_code;
    logic       pressed;
    logic [7:0] raw;
  } event_t;

  typedef struct packed {
    logic [1:0] kind;
    event_t     ev;
  } cmd_t;

  function automatic logic [7:0] ext_code(input logic [6:0] code);
    case (code)
      7'h48:   return 8'd128;
      7'h50:   return 8'd129;
      7'h4B:   return 8'd130;
      7'h4D:   return 8'd131;
      7'h49:   return 8'd132;
      7'h51:   return 8'd133;
      7'h47:   return 8'd134;
      7'h4F:   return 8'd135;
      7'h52:   return 8'd136;
      7'h53:   return 8'd137;
      7'h1D:   return KC_RCTRL;
      7'h38:   return KC_RALT;
      default: return KC_NONE;
    endcase
  endfunction

  function automatic logic [6:0] plain_ascii(input logic [6:0] code);
    case (code)
      7'h01: return 7'h1B; 7'h02: return 7'h31; 7'h03: return 7'h32; 7'h04: return 7'h33;
      7'h05: return 7'h34; 7'h06: return 7'h35; 7'h07: return 7'h36; 7'h08: return 7'h37;
      7'h09: return 7'h38; 7'h0A: return 7'h39; 7'h0B: return 7'h30; 7'h0C: return 7'h2D;
      7'h0D: return 7'h3D; 7'h0E: return 7'h08; 7'h0F: return 7'h09;
      7'h10: return 7'h71; 7'h11: return 7'h77; 7'h12: return 7'h65; 7'h13: return 7'h72;
      7'h14: return 7'h74; 7'h15: return 7'h79; 7'h16: return 7'h75; 7'h17: return 7'h69;
      7'h18: return 7'h6F; 7'h19: return 7'h70; 7'h1A: return 7'h5B; 7'h1B: return 7'h5D;
      7'h1C: return 7'h0A; 7'h1E: return 7'h61; 7'h1F: return 7'h73;
      7'h20: return 7'h64; 7'h21: return 7'h66; 7'h22: return 7'h67; 7'h23: return 7'h68;
      7'h24: return 7'h6A; 7'h25: return 7'h6B; 7'h26: return 7'h6C; 7'h27: return 7'h3B;
      7'h28: return 7'h27; 7'h29: return 7'h60; 7'h2B: return 7'h5C; 7'h2C: return 7'h7A;
      7'h2D: return 7'h78; 7'h2E: return 7'h63; 7'h2F: return 7'h76;
      7'h30: return 7'h62; 7'h31: return 7'h6E; 7'h32: return 7'h6D; 7'h33: return 7'h2C;
      7'h34: return 7'h2E; 7'h35: return 7'h2F; 7'h37: return 7'h2A; 7'h39: return 7'h20;
      7'h47: return 7'h37; 7'h48: return 7'h38; 7'h49: return 7'h39; 7'h4A: return 7'h2D;
      7'h4B: return 7'h34; 7'h4C: return 7'h35; 7'h4D: return 7'h36; 7'h4E: return 7'h2B;
      7'h4F: return 7'h31; 7'h50: return 7'h32; 7'h51: return 7'h33; 7'h52: return 7'h30;
      7'h53: return 7'h2E;
      default: return 7'h00;
    endcase
  endfunction

  // only the entries that differ from the plain map are listed
  function automatic logic [6:0] shifted_ascii(input logic [6:0] code);
    case (code)
      7'h02: return 7'h21; 7'h03: return 7'h40; 7'h04: return 7'h23; 7'h05: return 7'h24;
      7'h06: return 7'h25; 7'h07: return 7'h5E; 7'h08: return 7'h26; 7'h09: return 7'h2A;
      7'h0A: return 7'h28; 7'h0B: return 7'h29; 7'h0C: return 7'h5F; 7'h0D: return 7'h2B;
      7'h10: return 7'h51; 7'h11: return 7'h57; 7'h12: return 7'h45; 7'h13: return 7'h52;
      7'h14: return 7'h54; 7'h15: return 7'h59; 7'h16: return 7'h55; 7'h17: return 7'h49;
      7'h18: return 7'h4F; 7'h19: return 7'h50; 7'h1A: return 7'h7B; 7'h1B: return 7'h7D;
      7'h1E: return 7'h41; 7'h1F: return 7'h53;
      7'h20: return 7'h44; 7'h21: return 7'h46; 7'h22: return 7'h47; 7'h23: return 7'h48;
      7'h24: return 7'h4A; 7'h25: return 7'h4B; 7'h26: return 7'h4C; 7'h27: return 7'h3A;
      7'h28: return 7'h22; 7'h29: return 7'h7E; 7'h2B: return 7'h7C; 7'h2C: return 7'h5A;
      7'h2D: return 7'h58; 7'h2E: return 7'h43; 7'h2F: return 7'h56;
      7'h30: return 7'h42; 7'h31: return 7'h4E; 7'h32: return 7'h4D; 7'h33: return 7'h3C;
      7'h34: return 7'h3E; 7'h35: return 7'h3F;
      default: return plain_ascii(code);
    endcase
  endfunction

endpackage

// ===== hw/rtl/scs1kd_if.sv =====
interface scs1kd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] scan_byte;

  modport source (output valid, output op, output scan_byte, input ready);
  modport sink   (input valid, input op, input scan_byte, output ready);
endinterface

interface scs1kd_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [7:0] raw_scancode;
  logic       key_pressed;
  logic [7:0] key_code;
  logic [6:0] ascii_char;
  logic [3:0] mod_flags;
  logic       event_dropped;
  logic       queue_nonempty;

  modport source (output valid, output event_valid, output raw_scancode, output key_pressed,
                  output key_code, output ascii_char, output mod_flags, output event_dropped,
                  output queue_nonempty, input ready);
  modport sink   (input valid, input event_valid, input raw_scancode, input key_pressed,
                  input key_code, input ascii_char, input mod_flags, input event_dropped,
                  input queue_nonempty, output ready);
endinterface

// ===== hw/rtl/scs1kd_front.sv =====
module scs1kd_front (
  input  logic               clk,
  input  logic               rst,
  scs1kd_in_if.sink          in_ch,
  output scs1kd_pkg::cmd_t   cmd,
  output logic               cmd_valid,
  input  logic               cmd_ready
);
  import scs1kd_pkg::*;

  logic shift_held, ctrl_held, alt_held, caps_on, ext_pending;
  logic shift_next, ctrl_next, alt_next, caps_next, ext_next;
  logic       pressed;
  logic [6:0] code;
  logic [6:0] ch;
  logic [7:0] kc;
  logic       take;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign take        = in_ch.valid && cmd_ready;
  assign pressed     = !in_ch.scan_byte[7];
  assign code        = in_ch.scan_byte[6:0];

  always_comb begin
    shift_next = shift_held;
    ctrl_next  = ctrl_held;
    alt_next   = alt_held;
    caps_next  = caps_on;
    ext_next   = ext_pending;
    kc         = KC_NONE;
    ch         = 7'h00;
    cmd        = '0;
    if (in_ch.op == OP_POP) begin
      cmd.kind = CMD_POP;
    end else if (in_ch.scan_byte == BYTE_EXT) begin
      ext_next = 1'b1;
      cmd.kind = CMD_NONE;
    end else if (in_ch.scan_byte == BYTE_PAUSE) begin
      cmd.kind = CMD_NONE;
    end else begin
      if (ext_pending) begin
        ext_next = 1'b0;
        kc       = ext_code(code);
        if (kc == KC_RCTRL) begin
          ctrl_next = pressed;
        end else if (kc == KC_RALT) begin
          alt_next = pressed;
        end
      end else begin
        kc = {1'b0, code};
        if (code == SC_LSHIFT || code == SC_RSHIFT) begin
          shift_next = pressed;
        end else if (code == SC_CTRL) begin
          ctrl_next = pressed;
        end else if (code == SC_ALT) begin
          alt_next = pressed;
        end else if (code == SC_CAPS && pressed) begin
          caps_next = !caps_on;
        end
        if (pressed) begin
          ch = shift_next ? shifted_ascii(code) : plain_ascii(code);
          // caps flips letter case: bit 5 separates the two cases
          if (caps_next && ((ch inside {[7'h61:7'h7A]}) || (ch inside {[7'h41:7'h5A]}))) begin
            ch = ch ^ 7'h20;
          end
        end
      end
      cmd.kind        = CMD_PUSH;
      cmd.ev.raw      = in_ch.scan_byte;
      cmd.ev.pressed  = pressed;
      cmd.ev.key_code = kc;
      cmd.ev.ascii    = ch;
      cmd.ev.mods     = {caps_next, alt_next, ctrl_next, shift_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      alt_held    <= 1'b0;
      caps_on     <= 1'b0;
      ext_pending <= 1'b0;
    end else if (take) begin
      shift_held  <= shift_next;
      ctrl_held   <= ctrl_next;
      alt_held    <= alt_next;
      caps_on     <= caps_next;
      ext_pending <= ext_next;
    end
  end

endmodule

// ===== hw/rtl/scs1kd_cmd_fifo.sv =====
module scs1kd_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  scs1kd_pkg::cmd_t   push_cmd,
  input  logic               push_valid,
  output logic               push_ready,
  output scs1kd_pkg::cmd_t   pop_cmd,
  output logic               pop_valid,
  input  logic               pop_ready
);
  import scs1kd_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/scs1kd_back.sv =====
module scs1kd_back (
  input  logic               clk,
  input  logic               rst,
  input  scs1kd_pkg::cmd_t   cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  scs1kd_out_if.source       out_ch
);
  import scs1kd_pkg::*;

  event_t              store [QUEUE_SLOTS];
  logic [QIDX_W-1:0]   wr_idx, rd_idx, wr_next, rd_next, wr_inc, rd_inc;
  logic                fire, full, empty;
  logic                is_push, pop_hit;

  function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] i);
    if (i == QIDX_W'(QUEUE_SLOTS - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  assign cmd_ready = !out_ch.valid || out_ch.ready;
  assign fire      = cmd_valid && cmd_ready;
  assign wr_inc    = next_slot(wr_idx);
  assign rd_inc    = next_slot(rd_idx);
  assign full      = (wr_inc == rd_idx);
  assign empty     = (wr_idx == rd_idx);
  assign is_push   = (cmd.kind == CMD_PUSH);
  assign pop_hit   = (cmd.kind == CMD_POP) && !empty;

  always_comb begin
    wr_next = wr_idx;
    rd_next = rd_idx;
    if (fire) begin
      case (cmd.kind)
        CMD_PUSH: if (!full)  wr_next = wr_inc;
        CMD_POP:  if (!empty) rd_next = rd_inc;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx       <= '0;
      rd_idx       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      wr_idx <= wr_next;
      rd_idx <= rd_next;
      if (fire) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // output beat register; a pop reads the store straight into it
  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.queue_nonempty <= (wr_next != rd_next);
      out_ch.event_valid    <= is_push || pop_hit;
      out_ch.event_dropped  <= is_push && full;
      if (is_push) begin
        out_ch.raw_scancode <= cmd.ev.raw;
        out_ch.key_pressed  <= cmd.ev.pressed;
        out_ch.key_code     <= cmd.ev.key_code;
        out_ch.ascii_char   <= cmd.ev.ascii;
        out_ch.mod_flags    <= cmd.ev.mods;
      end else if (pop_hit) begin
        out_ch.raw_scancode <= store[rd_idx].raw;
        out_ch.key_pressed  <= store[rd_idx].pressed;
        out_ch.key_code     <= store[rd_idx].key_code;
        out_ch.ascii_char   <= store[rd_idx].ascii;
        out_ch.mod_flags    <= store[rd_idx].mods;
      end else begin
        out_ch.raw_scancode <= 8'h00;
        out_ch.key_pressed  <= 1'b0;
        out_ch.key_code     <= 8'h00;
        out_ch.ascii_char   <= 7'h00;
        out_ch.mod_flags    <= 4'h0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.kind == CMD_PUSH && !full) begin
      store[wr_idx] <= cmd.ev;
    end
  end

  a_drop_is_event: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!out_ch.event_dropped || out_ch.event_valid))
    else $error("dropped flag on a beat without an event");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd.kind == CMD_POP && empty) |=> !out_ch.event_valid)
    else $error("pop of empty queue returned an event");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd.kind == CMD_PUSH && full) |=> (wr_idx == $past(wr_idx)))
    else $error("write index moved on a dropped event");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (wr_idx == rd_idx))
    else $error("queue not empty after reset");

endmodule

// ===== hw/rtl/scancode_set1_keyboard_decoder.sv =====
// Scancode set 1 keyboard decoder with a queue of key events.
//
// in_ch carries one beat per item: op 0 delivers a raw keyboard byte, op 1
// asks for the oldest queued event. out_ch returns exactly one beat per item,
// in order. Prefix bytes (E0, E1) and pops of an empty queue give a beat
// with event_valid low and only queue_nonempty meaningful.
//
// The command queue takes the input beat and the back registers the result
// into the output register. The decoder takes one item per cycle while
// out_ch is not stalled. The front decodes bytes and tracks the modifier
// state; the back owns the event queue (at most one store access per item)
// and the output register. A two-entry command queue sits between.
//
// Reset clears modifiers, the extended prefix and both queue indexes; the
// event store itself is not cleared and holds nothing readable until written.
// When out_ch stalls the result is held in the output register, the command
// queue absorbs two more items and then in_ch.ready drops.
module scancode_set1_keyboard_decoder (
  input  logic          clk,
  input  logic          rst,
  scs1kd_in_if.sink     in_ch,
  scs1kd_out_if.source  out_ch
);
  import scs1kd_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  scs1kd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  scs1kd_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  scs1kd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule
